### hdl/pwmps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmps_pkg
// Shared constants, types and the prescaler rate table for the PWM prescaler,
// period and duty selection block.
// ----------------------------------------------------------------------------
package pwmps_pkg;

  // widths of the tick conversion datapath
  localparam int unsigned RATE_W  = 25;  // largest tick rate is 24 MHz
  localparam int unsigned NS_W    = 32;
  localparam int unsigned PROD_W  = RATE_W + NS_W;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned CODE_W  = 4;

  localparam logic [29:0] NS_PER_S = 30'd1000000000;
  // floor(2^56 / 1e9), reciprocal used for the quotient estimate
  localparam logic [26:0] RECIP_M = 27'd72057594;

  localparam int unsigned PERIOD_MAX_DEF = 65535;
  localparam logic [DUTY_W-1:0] DUTY_LIMIT = 16'hFFFF;

  // register stages inside one tick converter
  localparam int unsigned TICKS_LAT = 4;

  // codes with a nonzero divisor, in ascending order so lower codes win ties
  localparam int unsigned NUM_CELLS = 11;
  localparam logic [CODE_W-1:0] CELL_CODE [NUM_CELLS] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd15
  };

  // running best candidate handed from cell to cell
  typedef struct packed {
    logic [NS_W-1:0]    req_period;
    logic [NS_W-1:0]    duty_ns;
    logic [COUNT_W-1:0] lead_count;
    logic [CODE_W-1:0]  best_code;
  } item_t;

  // tick rate of a code: 24 MHz divided by the code's divisor, truncated
  function automatic logic [RATE_W-1:0] rate_of(input logic [CODE_W-1:0] code);
    logic [RATE_W-1:0] r;
    r = '0;
    case (code)
      4'd0:    r = 25'd200000;    // divide by 120
      4'd1:    r = 25'd133333;    // divide by 180
      4'd2:    r = 25'd100000;    // divide by 240
      4'd3:    r = 25'd66666;     // divide by 360
      4'd4:    r = 25'd50000;     // divide by 480
      4'd8:    r = 25'd2000;      // divide by 12000
      4'd9:    r = 25'd1000;      // divide by 24000
      4'd10:   r = 25'd666;       // divide by 36000
      4'd11:   r = 25'd500;       // divide by 48000
      4'd12:   r = 25'd333;       // divide by 72000
      4'd15:   r = 25'd24000000;  // divide by 1
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### hdl/pwmps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmps_if
// Valid/ready channels for requests and results of the PWM prescaler block.
// ----------------------------------------------------------------------------
interface pwmps_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] req_period;
  logic [31:0] duty_ns;

  modport source (output valid, output req_period, output duty_ns, input ready);
  modport sink   (input valid, input req_period, input duty_ns, output ready);
endinterface

interface pwmps_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  prescaler_code;
  logic [16:0] period_count;
  logic [15:0] duty_count;
  logic        error;
  logic        prescaler_changed;

  modport source (output valid, output prescaler_code, output period_count,
                  output duty_count, output error, output prescaler_changed,
                  input ready);
  modport sink   (input valid, input prescaler_code, input period_count,
                  input duty_count, input error, input prescaler_changed,
                  output ready);
endinterface

### hdl/pwmps_ticks.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmps_ticks
// Pipelined conversion floor(rate * ns / 1e9) with range flags, four stages.
// ----------------------------------------------------------------------------
module pwmps_ticks #(
  parameter int unsigned HI_LIMIT = pwmps_pkg::PERIOD_MAX_DEF + 2
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [pwmps_pkg::RATE_W-1:0]      rate_i,
  input  logic [pwmps_pkg::NS_W-1:0]        ns_i,
  output logic [pwmps_pkg::COUNT_W-1:0]     q_o,
  output logic                              ge_one_o,
  output logic                              ge_hi_o
);
  import pwmps_pkg::*;

  // product bound at which the quotient reaches HI_LIMIT
  localparam logic [PROD_W-1:0] HiBound = PROD_W'(HI_LIMIT) * PROD_W'(NS_PER_S);

  logic [PROD_W-1:0]  x1_q, x2_q, x3_q;
  logic [COUNT_W-1:0] qe2_q, qe3_q, q4_q;
  logic [46:0]        p3_q;
  logic               one2_q, one3_q, one4_q;
  logic               hi2_q, hi3_q, hi4_q;
  logic [58:0]        qe_prod;
  logic               incr;

  // estimate from the top bits, at most one below the true quotient
  assign qe_prod = 59'(x1_q[55:24]) * 59'(RECIP_M);
  assign incr    = x3_q >= (PROD_W'(p3_q) + PROD_W'(NS_PER_S));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q   <= PROD_W'(rate_i) * PROD_W'(ns_i);

      x2_q   <= x1_q;
      qe2_q  <= qe_prod[48:32];
      one2_q <= x1_q >= PROD_W'(NS_PER_S);
      hi2_q  <= x1_q >= HiBound;

      x3_q   <= x2_q;
      qe3_q  <= qe2_q;
      p3_q   <= 47'(qe2_q) * 47'(NS_PER_S);
      one3_q <= one2_q;
      hi3_q  <= hi2_q;

      q4_q   <= qe3_q + COUNT_W'(incr);
      one4_q <= one3_q;
      hi4_q  <= hi3_q;
    end
  end

  assign q_o      = q4_q;
  assign ge_one_o = one4_q;
  assign ge_hi_o  = hi4_q;

endmodule

### hdl/pwmps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmps_cell
// One prescaler candidate: converts the period at its rate and keeps the
// running best when its period is in range and strictly larger.
// ----------------------------------------------------------------------------
module pwmps_cell #(
  parameter logic [3:0]  CODE       = 4'd0,
  parameter int unsigned PERIOD_MAX = pwmps_pkg::PERIOD_MAX_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  pwmps_pkg::item_t item_i,
  output logic             valid_o,
  output pwmps_pkg::item_t item_o
);
  import pwmps_pkg::*;

  logic [COUNT_W-1:0]   q;
  logic                 ge_one, ge_hi;
  logic                 take;
  item_t                dly_q [TICKS_LAT];
  logic [TICKS_LAT-1:0] vld_q;
  item_t                item_d, item_q;
  logic                 valid_q;

  pwmps_ticks #(
    .HI_LIMIT (PERIOD_MAX + 2)
  ) u_ticks (
    .clk_i    (clk_i),
    .en_i     (en_i),
    .rate_i   (rate_of(CODE)),
    .ns_i     (item_i.req_period),
    .q_o      (q),
    .ge_one_o (ge_one),
    .ge_hi_o  (ge_hi)
  );

  // item rides alongside the converter
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dly_q[0] <= item_i;
      for (int i = 1; i < TICKS_LAT; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
      item_q <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      vld_q   <= {vld_q[TICKS_LAT-2:0], valid_i};
      valid_q <= vld_q[TICKS_LAT-1];
    end
  end

  assign take = ge_one && !ge_hi && (q > dly_q[TICKS_LAT-1].lead_count);

  always_comb begin
    item_d = dly_q[TICKS_LAT-1];
    if (take) begin
      item_d.lead_count = q;
      item_d.best_code  = CODE;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### hdl/pwm_prescaler_period_duty_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_prescaler_period_duty_select
// Picks the PWM prescaler code that gives the finest period for a request in
// nanoseconds, and converts period and duty to prescaled ticks.
// ----------------------------------------------------------------------------
// A request (req_period, duty_ns) is taken in every cycle in which in_i.ready
// is high, and each request yields exactly one result on out_o, in order. The
// request walks a row of eleven cells, one per prescaler code with a nonzero
// divisor (lowest code first); each cell turns the period into ticks at its
// rate off a 24 MHz clock and keeps the candidate if its count lies in
// 1..PERIOD_MAX+1 and beats the best so far, so equal counts keep the lower
// code. A final converter turns the duty into ticks at the chosen rate and
// saturates it at 65535. When no code fits, error is set and all other result
// fields read zero. The last chosen code is remembered (zero after reset) and
// prescaler_changed flags a different choice; an error result leaves it alone.
// Throughput is one transfer per cycle while the row is not stalled; from input
// transfer to result valid a request passes five register stages per cell
// (four in the tick conversion multiply/reciprocal pipeline, one for the
// compare), four in the duty converter and one output register. A result that
// waits on out_o only stalls the row once an item reaches the end of it.
// ----------------------------------------------------------------------------
module pwm_prescaler_period_duty_select #(
  parameter int unsigned PERIOD_MAX = pwmps_pkg::PERIOD_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pwmps_in_if.sink    in_i,
  pwmps_out_if.source out_o
);
  import pwmps_pkg::*;

  // row of cells, entry 0 is the incoming request
  item_t                chain_item [NUM_CELLS+1];
  logic [NUM_CELLS:0]   chain_vld;

  // duty converter and its side delay line
  logic [COUNT_W-1:0]   duty_q_raw;
  logic                 duty_ge_one, duty_ge_hi;
  item_t                tail_q [TICKS_LAT];
  logic [TICKS_LAT-1:0] tail_vld_q;
  item_t                tail;
  logic                 tail_vld;

  // output register and remembered code
  logic                 adv;
  logic                 load;
  logic                 out_valid_d, out_valid_q;
  logic [CODE_W-1:0]    code_d, code_q;
  logic [COUNT_W-1:0]   period_d, period_q;
  logic [DUTY_W-1:0]    duty_d, duty_q;
  logic                 err_d, err_q;
  logic                 chg_d, chg_q;
  logic [CODE_W-1:0]    cur_d, cur_q;

  // whole row moves together; it only halts when the last stage holds a
  // result and the output register is full and not being drained
  assign tail     = tail_q[TICKS_LAT-1];
  assign tail_vld = tail_vld_q[TICKS_LAT-1];
  assign adv      = !(out_valid_q && !out_o.ready && tail_vld);
  assign load     = adv && tail_vld;
  assign in_i.ready = adv;

  // fresh request starts with no candidate
  always_comb begin
    chain_item[0].req_period = in_i.req_period;
    chain_item[0].duty_ns    = in_i.duty_ns;
    chain_item[0].lead_count = '0;
    chain_item[0].best_code  = '0;
  end
  assign chain_vld[0] = in_i.valid;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    pwmps_cell #(
      .CODE       (CELL_CODE[g]),
      .PERIOD_MAX (PERIOD_MAX)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (chain_vld[g]),
      .item_i  (chain_item[g]),
      .valid_o (chain_vld[g+1]),
      .item_o  (chain_item[g+1])
    );
  end

  // duty at the winning rate, saturation bound is DUTY_LIMIT + 1 ticks
  pwmps_ticks #(
    .HI_LIMIT (int'(DUTY_LIMIT) + 1)
  ) u_duty (
    .clk_i    (clk_i),
    .en_i     (adv),
    .rate_i   (rate_of(chain_item[NUM_CELLS].best_code)),
    .ns_i     (chain_item[NUM_CELLS].duty_ns),
    .q_o      (duty_q_raw),
    .ge_one_o (duty_ge_one),
    .ge_hi_o  (duty_ge_hi)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tail_q[0] <= chain_item[NUM_CELLS];
      for (int i = 1; i < TICKS_LAT; i++) begin
        tail_q[i] <= tail_q[i-1];
      end
    end
  end

  // result fields, zeroed on error
  always_comb begin
    err_d    = (tail.lead_count == '0);
    code_d   = tail.best_code;
    period_d = tail.lead_count;
    if (duty_ge_hi) begin
      duty_d = DUTY_LIMIT;
    end else if (duty_ge_one) begin
      duty_d = duty_q_raw[DUTY_W-1:0];
    end else begin
      duty_d = '0;
    end
    chg_d = (cur_q != tail.best_code);
    cur_d = cur_q;
    if (err_d) begin
      code_d   = '0;
      period_d = '0;
      duty_d   = '0;
      chg_d    = 1'b0;
    end else begin
      cur_d = tail.best_code;
    end
  end

  // output valid: filled by a finished item, emptied by a transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = tail_vld || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q   <= code_d;
      period_q <= period_d;
      duty_q   <= duty_d;
      err_q    <= err_d;
      chg_q    <= chg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_vld_q  <= '0;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
    end else begin
      if (adv) begin
        tail_vld_q <= {tail_vld_q[TICKS_LAT-2:0], chain_vld[NUM_CELLS]};
      end
      out_valid_q <= out_valid_d;
      if (load) begin
        cur_q <= cur_d;
      end
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.prescaler_code    = code_q;
  assign out_o.period_count      = period_q;
  assign out_o.duty_count        = duty_q;
  assign out_o.error             = err_q;
  assign out_o.prescaler_changed = chg_q;

endmodule
